/* rtl/grid_ray_march_distance_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the grid ray marcher
// Assertion macros used at the end of the top level. They compile to nothing
// when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_MARCH_DISTANCE_DEFINES_SVH
`define GRID_RAY_MARCH_DISTANCE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every clock edge outside reset.
`define RGM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid ray marcher: check failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define RGM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid ray marcher: check failed");
`else
`define RGM_ASSERT_IMPL(lbl, ante, cons)
`define RGM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/rgm_pkg.sv */
// ----------------------------------------------------------------------------
// Grid ray marcher package
// Shared constants, register indexes and types of the ray marcher.
// ----------------------------------------------------------------------------
package rgm_pkg;

  // Default map side length in cells.
  localparam int MAP_DIM_DEF = 64;

  // Fixed formats.
  localparam int FRAC_BITS  = 10;   // fraction bits of positions and distances
  localparam int ANGLE_BITS = 12;   // angle units: 2^ANGLE_BITS per turn
  localparam int POS_FRAC   = 32;   // fraction bits of the marching position
  localparam int TRIG_FRAC  = 14;   // trig values are Q2.14
  localparam int TRIG_ONE   = 16384;
  localparam int POLY_A     = 25736;
  localparam int POLY_B     = 10512;
  localparam int POLY_C     = 1160;

  // Field widths.
  localparam int SPC_W   = 8;
  localparam int MAXD_W  = 6;
  localparam int PLAY_W  = 16;
  localparam int CELL_W  = 6;
  localparam int DIST_W  = 16;
  localparam int STEP_W  = SPC_W + MAXD_W;
  localparam int MAG_W   = 15;                       // trig magnitude, 0..16384
  localparam int DIV_W   = MAG_W + POS_FRAC - TRIG_FRAC; // divider dividend width
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_CELL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ANGLE     = 3'd4;

  // Request kinds.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CAST  = 1'b1;

  // Configuration as seen by the march engine.
  typedef struct packed {
    logic [SPC_W-1:0]      spc;
    logic [MAXD_W-1:0]     maxd;
    logic [PLAY_W-1:0]     px;
    logic [PLAY_W-1:0]     py;
    logic [ANGLE_BITS-1:0] view;
  } cfg_t;

  // One classified request in the queue.
  typedef struct packed {
    logic                  is_cast;
    logic                  wr_ok;
    logic [CELL_W-1:0]     col;
    logic [CELL_W-1:0]     row;
    logic                  solid;
    logic [ANGLE_BITS-1:0] angle;
  } item_t;

  // Status of the march engine.
  typedef struct packed {
    logic clearing;
    logic busy;
  } bstat_t;

endpackage

/* rtl/rgm_front.sv */
// ----------------------------------------------------------------------------
// Grid ray marcher front end
// Accepts request transactions, classifies them and holds them in a
// two-entry queue for the march engine.
// ----------------------------------------------------------------------------
module rgm_front
  import rgm_pkg::*;
#(
  parameter int MAP_DIM = MAP_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cell_col[5:0], cell_row[11:6], cell_solid[12],
                                  // ray_heading[24:13], zero fill
  input  logic        in_tuser,   // req_type
  output item_t       q_item,
  output logic        q_valid,
  input  logic        q_pop
);

  item_t       ent_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  item_t       new_item;

  // Classify the incoming request.
  always_comb begin
    new_item.is_cast = (in_tuser == REQ_CAST);
    new_item.col     = in_tdata[5:0];
    new_item.row     = in_tdata[11:6];
    new_item.solid   = in_tdata[12];
    new_item.angle   = in_tdata[24:13];
    new_item.wr_ok   = (32'(new_item.col) < MAP_DIM) && (32'(new_item.row) < MAP_DIM);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = ent_r[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= new_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* rtl/rgm_div.sv */
// ----------------------------------------------------------------------------
// Grid ray marcher divider
// Restoring divider, one quotient bit per cycle, for an unsigned dividend
// by the steps-per-cell divisor.
// ----------------------------------------------------------------------------
module rgm_div
  import rgm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [SPC_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r;
  logic [SPC_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [SPC_W:0]   trial;
  logic             fits;

  // One restoring step.
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DIV_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DIV_W-2:0], fits};
      rem_r <= fits ? SPC_W'(trial - {1'b0, divisor}) : SPC_W'(trial);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/rgm_march.sv */
// ----------------------------------------------------------------------------
// Grid ray marcher engine
// Holds the cell map, evaluates the trig polynomials on a shared multiplier,
// marches the ray one cell read per step and forms the corrected distance.
// ----------------------------------------------------------------------------
module rgm_march
  import rgm_pkg::*;
#(
  parameter int MAP_DIM = MAP_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  item_t             q_item,
  input  logic              q_valid,
  output logic              q_pop,
  output bstat_t            st,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DIST_W-1:0] out_dist,
  output logic              out_hit
);

  localparam int CA        = $clog2(MAP_DIM);
  localparam int IW        = (((CA + 1) > 7) ? (CA + 1) : 7) + 1;
  localparam int POS_W     = POS_FRAC + IW;
  localparam int MEM_DEPTH = MAP_DIM * MAP_DIM;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int SHR       = (FRAC_BITS <= TRIG_FRAC) ? (TRIG_FRAC - FRAC_BITS) : 0;
  localparam int SHL       = (FRAC_BITS > TRIG_FRAC) ? (FRAC_BITS - TRIG_FRAC) : 0;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  // Sequencer states.
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_TRIG  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_ADDR  = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_MULT  = 4'd6;
  localparam logic [3:0] S_FDIV  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // Trig jobs.
  localparam logic [1:0] J_COS  = 2'd0;
  localparam logic [1:0] J_SIN  = 2'd1;
  localparam logic [1:0] J_CORR = 2'd2;

  logic                   map_mem [MEM_DEPTH];
  logic [3:0]             state_r, state_nxt;
  logic [MEM_AW-1:0]      clr_r;
  logic [1:0]             phase_r;
  logic [1:0]             job_r;
  logic [ANGLE_BITS-1:0]  angle_r;
  logic [SPC_W-1:0]       spc_r;
  logic [15:0]            acc_r;
  logic [15:0]            u2_r;
  logic [MAG_W-1:0]       corr_mag_r;
  logic                   corr_neg_r;
  logic signed [POS_W-1:0] dx_r, dy_r, pos_x_r, pos_y_r;
  logic [STEP_W-1:0]      n_r, limit_r;
  logic                   rd_r, oob_r, hit_r;
  logic                   out_valid_r;
  logic [DIST_W-1:0]      out_dist_r;
  logic [DIST_W-1:0]      res_dist_r;
  logic                   res_hit_r;

  logic [ANGLE_BITS-1:0]  job_angle;
  logic [15:0]            turn;
  logic [MAG_W-1:0]       u_c;
  logic                   neg_c;
  logic [15:0]            mul_a, mul_b;
  logic [31:0]            prod;
  logic [16:0]            prod_sh;
  logic [MAG_W-1:0]       mag_c;
  logic                   div_start, div_done;
  logic [DIV_W-1:0]       div_dividend, div_q;
  logic signed [POS_W-1:0] q_signed;
  logic [IW-1:0]          col_i, row_i;
  logic                   oob_c;
  logic [MEM_AW-1:0]      rd_addr, wr_addr;
  logic                   mem_we, mem_wd;
  logic                   solid_c;
  logic                   corr_pos;

  // Angle of the current trig job and its quadrant reduction.
  always_comb begin
    case (job_r)
      J_COS:   job_angle = angle_r + QUARTER;
      J_SIN:   job_angle = angle_r;
      J_CORR:  job_angle = angle_r - cfg.view + QUARTER;
      default: job_angle = angle_r;
    endcase
    turn  = 16'(job_angle) << (16 - ANGLE_BITS);
    u_c   = turn[14] ? MAG_W'(TRIG_ONE - 32'(turn[13:0])) : MAG_W'(turn[13:0]);
    neg_c = turn[15];
  end

  // Shared multiplier: polynomial terms, then steps times correction.
  always_comb begin
    if (state_r == S_MULT) begin
      mul_a = 16'(n_r);
      mul_b = 16'(corr_mag_r);
    end else begin
      case (phase_r)
        2'd0:    begin mul_a = 16'(u_c); mul_b = 16'(u_c); end
        2'd1:    begin mul_a = u2_r;     mul_b = 16'(POLY_C); end
        2'd2:    begin mul_a = u2_r;     mul_b = 16'(POLY_B) - acc_r; end
        default: begin mul_a = 16'(u_c); mul_b = 16'(POLY_A) - acc_r; end
      endcase
    end
    prod    = mul_a * mul_b;
    prod_sh = 17'(prod >> TRIG_FRAC);
    mag_c   = (prod_sh > 17'(TRIG_ONE)) ? MAG_W'(TRIG_ONE) : MAG_W'(prod_sh);
  end

  // Divider feed.
  assign corr_pos = !corr_neg_r && (corr_mag_r != '0);
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {mag_c, (POS_FRAC - TRIG_FRAC)'(0)};
    if (state_r == S_TRIG && phase_r == 2'd3 && job_r != J_CORR) begin
      div_start = 1'b1;
    end
    if (state_r == S_MULT && corr_pos) begin
      div_start    = 1'b1;
      div_dividend = DIV_W'(prod >> SHR) << SHL;
    end
  end

  rgm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (spc_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_signed = neg_c ? -POS_W'(div_q) : POS_W'(div_q);

  // Cell lookup from the current position; outside the map counts as solid.
  always_comb begin
    col_i   = pos_x_r[POS_W-1:POS_FRAC];
    row_i   = pos_y_r[POS_W-1:POS_FRAC];
    oob_c   = pos_x_r[POS_W-1] || pos_y_r[POS_W-1] ||
              (32'(col_i) >= MAP_DIM) || (32'(row_i) >= MAP_DIM);
    rd_addr = MEM_AW'(32'(row_i) * MAP_DIM + 32'(col_i));
    wr_addr = (state_r == S_CLEAR) ? clr_r
                                   : MEM_AW'(32'(q_item.row) * MAP_DIM + 32'(q_item.col));
    q_pop   = (state_r == S_IDLE) && q_valid;
    mem_we  = (state_r == S_CLEAR) || (q_pop && !q_item.is_cast && q_item.wr_ok);
    mem_wd  = (state_r == S_CLEAR) ? 1'b0 : q_item.solid;
    solid_c = oob_r || rd_r;
  end

  // Map store: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[wr_addr] <= mem_wd;
    end
    rd_r <= map_mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == MEM_AW'(MEM_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (q_pop && q_item.is_cast) state_nxt = S_TRIG;
      S_TRIG: begin
        if (phase_r == 2'd3) begin
          state_nxt = (job_r == J_CORR) ? S_ADDR : S_DIV;
        end
      end
      S_DIV:   if (div_done) state_nxt = S_TRIG;
      S_ADDR:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = (solid_c || n_r >= limit_r) ? S_MULT : S_ADDR;
      S_MULT:  state_nxt = corr_pos ? S_FDIV : S_OUT;
      S_FDIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        angle_r <= q_item.angle;
        spc_r   <= (cfg.spc == '0) ? SPC_W'(1) : cfg.spc;
        job_r   <= J_COS;
        phase_r <= 2'd0;
      end
      S_TRIG: begin
        phase_r <= phase_r + 1'b1;
        acc_r   <= 16'(prod_sh);
        if (phase_r == 2'd0) begin
          u2_r <= 16'(prod_sh);
        end
        if (phase_r == 2'd3 && job_r == J_CORR) begin
          corr_mag_r <= mag_c;
          corr_neg_r <= neg_c;
          pos_x_r    <= (POS_W'(cfg.px) << (POS_FRAC - FRAC_BITS)) +
                        (POS_W'(1) << (POS_FRAC - 1));
          pos_y_r    <= (POS_W'(cfg.py) << (POS_FRAC - FRAC_BITS)) +
                        (POS_W'(1) << (POS_FRAC - 1));
          n_r        <= '0;
          limit_r    <= STEP_W'(cfg.maxd) * STEP_W'(spc_r);
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (job_r == J_COS) begin
            dx_r <= q_signed;
          end else begin
            dy_r <= q_signed;
          end
          job_r <= job_r + 1'b1;
        end
      end
      S_ADDR: begin
        oob_r <= oob_c;
      end
      S_CHECK: begin
        hit_r <= solid_c;
        if (!solid_c && n_r < limit_r) begin
          pos_x_r <= pos_x_r + dx_r;
          pos_y_r <= pos_y_r + dy_r;
          n_r     <= n_r + 1'b1;
        end
      end
      S_MULT: begin
        out_dist_r <= '0;
      end
      S_FDIV: begin
        if (div_done) begin
          out_dist_r <= (div_q > DIV_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                           : DIST_W'(div_q);
        end
      end
      default: begin
      end
    endcase
  end

  // The output register holds the distance and hit until taken.
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      res_dist_r <= out_dist_r;
      res_hit_r  <= hit_r;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_dist    = res_dist_r;
  assign out_hit     = res_hit_r;
  assign st.clearing = (state_r == S_CLEAR);
  assign st.busy     = (state_r != S_CLEAR) && (state_r != S_IDLE);

endmodule

/* rtl/grid_ray_march_distance.sv */
// ----------------------------------------------------------------------------
// Grid ray marcher, top level
// Casts fixed-step rays over a solid/open cell map and returns the
// fisheye-corrected wall distance.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in_ stream. tuser 0 writes one map cell (ignored when
// the address lies outside the map), tuser 1 casts a ray along the heading in
// tdata. A cast gives one out_ transaction: distance in tdata, hit flag in
// tuser; a map write gives none. Configuration registers (steps per cell, max
// distance, player position, view angle) must be written on the cfg_ port
// only while the block is idle; the block itself does not enforce this.
// Work per request: a map write is done while the engine stays idle. A cast
// runs three four-step trig evaluations on the shared multiplier and up to
// three divisions, then marches, each march step a map read and then a
// position step; at the defaults up to 550 march steps.
// After reset a clearing pass over the MAP_DIM*MAP_DIM cells (4096 at the
// default) opens every cell; requests queue meanwhile. A two-entry queue lets
// the input keep flowing while the engine works, and a held result waits in
// the output register while the engine goes on with map writes.
// ----------------------------------------------------------------------------
`include "grid_ray_march_distance_defines.svh"

module grid_ray_march_distance
  import rgm_pkg::*;
#(
  parameter int MAP_DIM = MAP_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // cell_col[5:0], cell_row[11:6],
                                            // cell_solid[12], ray_heading[24:13]
  input  logic                  in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // wall_distance[15:0]
  output logic                  out_tuser,  // hit_wall
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg_r;
  item_t  q_item;
  logic   q_valid;
  logic   pop;
  bstat_t st;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spc  <= SPC_W'(50);
      cfg_r.maxd <= MAXD_W'(11);
      cfg_r.px   <= '0;
      cfg_r.py   <= '0;
      cfg_r.view <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEPS_PER_CELL: cfg_r.spc  <= cfg_data[SPC_W-1:0];
        CFG_MAX_DISTANCE:   cfg_r.maxd <= cfg_data[MAXD_W-1:0];
        CFG_PLAYER_X:       cfg_r.px   <= cfg_data[PLAY_W-1:0];
        CFG_PLAYER_Y:       cfg_r.py   <= cfg_data[PLAY_W-1:0];
        CFG_VIEW_ANGLE:     cfg_r.view <= cfg_data[ANGLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  rgm_front #(.MAP_DIM(MAP_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (pop)
  );

  rgm_march #(.MAP_DIM(MAP_DIM)) u_march (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (pop),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_dist   (out_tdata),
    .out_hit    (out_tuser)
  );

  // No request leaves the queue during the clearing pass.
  `RGM_ASSERT_IMPL(a_no_pop_clear, st.clearing, !pop)
  // A new result only follows engine work.
  `RGM_ASSERT_IMPL(a_result_after_work, $rose(out_tvalid), $past(st.busy))
  // A cast taken from the queue occupies the engine.
  `RGM_ASSERT_NEXT(a_cast_busy, pop && q_item.is_cast, st.busy)

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the grid ray marcher
// Streams map writes and ray casts through the block in phases, rewriting the
// configuration registers while the block is idle. A built-in predictor marches
// each ray over its own copy of the map and checks every distance and hit flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rgm_pkg::*;

  typedef struct {
    logic        kind;
    logic [5:0]  col;
    logic [5:0]  row;
    logic        solid;
    logic [11:0] angle;
  } ray_req_t;

  typedef struct {
    logic [15:0] wdist;
    logic        hit;
  } ray_res_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;   // cell_col[5:0], cell_row[11:6], cell_solid[12],
                                     // ray_heading[24:13]
  logic                  in_tuser;   // req_type
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;  // wall_distance[15:0]
  logic                  out_tuser;  // hit_wall
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: map image and register copies.
  logic        map_img [0:4095];
  logic [7:0]  m_spc;
  logic [5:0]  m_maxd;
  logic [15:0] m_px;
  logic [15:0] m_py;
  logic [11:0] m_view;

  ray_req_t pend_q[$];
  ray_res_t dist_q[$];
  int       err_cnt;
  logic     hold_send;
  int       gap_left;
  int       burst_left;
  int       stall_cnt;
  logic     stall_mode;
  logic [15:0] stall_pat;
  longint   cyc;
  logic     in_taken;

  grid_ray_march_distance u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock: 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Quarter-turn sine polynomial, Q14 in and out.
  function automatic longint qsine(input longint u);
    longint u2;
    longint inner;
    longint mid;
    longint s;
    u2 = (u * u) >> 14;
    inner = POLY_B - ((u2 * POLY_C) >> 14);
    mid = POLY_A - ((u2 * inner) >> 14);
    s = (u * mid) >> 14;
    if (s > TRIG_ONE) s = TRIG_ONE;
    return s;
  endfunction

  function automatic longint sine_q14(input int unsigned angle);
    int unsigned t;
    int unsigned quad;
    int unsigned frac;
    longint s;
    t = ((angle & 32'hFFF) << 4) & 32'hFFFF;
    quad = t >> 14;
    frac = t & 32'h3FFF;
    if (quad[0]) s = qsine(16384 - frac);
    else s = qsine(frac);
    return quad[1] ? -s : s;
  endfunction

  function automatic longint cosine_q14(input int unsigned angle);
    return sine_q14((angle & 32'hFFF) + 1024);
  endfunction

  // Per-step increment with 32 fraction bits, truncated toward zero.
  function automatic longint step_inc(input longint trig, input longint spc);
    longint q;
    q = ((trig < 0 ? -trig : trig) << 18) / spc;
    return trig < 0 ? -q : q;
  endfunction

  function automatic logic cell_blocked(input longint px, input longint py);
    longint col;
    longint row;
    if (px < 0 || py < 0) return 1'b1;
    col = px >>> 32;
    row = py >>> 32;
    if (col >= 64 || row >= 64) return 1'b1;
    return map_img[row * 64 + col];
  endfunction

  // March one ray and compute the corrected distance.
  function automatic ray_res_t march_ray(input logic [11:0] ang);
    ray_res_t r;
    longint spc;
    longint limit;
    longint n;
    longint px;
    longint py;
    longint dx;
    longint dy;
    longint corr;
    longint d;
    logic [11:0] rel;
    spc = (m_spc == 0) ? 1 : longint'(m_spc);
    dx = step_inc(cosine_q14(ang), spc);
    dy = step_inc(sine_q14(ang), spc);
    px = (longint'(m_px) << 22) + (longint'(1) << 31);
    py = (longint'(m_py) << 22) + (longint'(1) << 31);
    limit = longint'(m_maxd) * spc;
    n = 0;
    while (!cell_blocked(px, py) && n < limit) begin
      px += dx;
      py += dy;
      n++;
    end
    r.hit = cell_blocked(px, py);
    rel = ang - m_view;
    corr = cosine_q14(rel);
    if (corr <= 0) begin
      d = 0;
    end else begin
      d = ((n * corr) << FRAC_BITS) / (spc << 14);
      if (d > 65535) d = 65535;
    end
    r.wdist = d[15:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch: %s got %0d expected %0d at cycle %0d", what, got, want, cyc);
    err_cnt++;
  endtask

  // Input acceptance as seen at the rising edge, used by the driver.
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
  end

  // Input driver: bursts of items with random gaps.
  always @(negedge clk) begin
    ray_req_t r;
    logic     nvalid;
    if (rst_n) begin
      nvalid = in_tvalid;
      if (!in_tvalid || in_taken) begin
        nvalid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0 && !hold_send) begin
          r = pend_q.pop_front();
          nvalid = 1'b1;
          in_tuser <= r.kind;
          in_tdata <= {7'd0, r.angle, r.solid, r.row, r.col};
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_tvalid <= nvalid;
    end
  end

  // Output stall pattern, switching between free flow and a stall mask.
  always @(negedge clk) begin
    stall_cnt++;
    if (stall_cnt % 300 == 0) begin
      stall_mode = 1'($urandom_range(0, 1));
      stall_pat = 16'($urandom);
    end
    out_tready <= stall_mode ? stall_pat[stall_cnt % 16] : 1'b1;
  end

  // Monitor: predict on input transactions, check on output transactions.
  always @(posedge clk) begin
    ray_res_t want;
    cyc++;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEPS_PER_CELL: m_spc = cfg_data[7:0];
          CFG_MAX_DISTANCE:   m_maxd = cfg_data[5:0];
          CFG_PLAYER_X:       m_px = cfg_data;
          CFG_PLAYER_Y:       m_py = cfg_data;
          CFG_VIEW_ANGLE:     m_view = cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == REQ_WRITE) begin
          map_img[{in_tdata[11:6], in_tdata[5:0]}] = in_tdata[12];
        end else begin
          dist_q.push_back(march_ray(in_tdata[24:13]));
        end
      end
      if (out_tvalid && out_tready) begin
        if (dist_q.size() == 0) begin
          report("unexpected result, distance", 32'(out_tdata), 32'd0);
        end else begin
          want = dist_q.pop_front();
          if (out_tdata !== want.wdist)
            report("wall_distance", 32'(out_tdata), 32'(want.wdist));
          if (out_tuser !== want.hit)
            report("hit_wall", 32'(out_tuser), 32'(want.hit));
        end
      end
    end
    if (cyc > 5000000) begin
      $display("timeout at cycle %0d", cyc);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input int spc, input int maxd, input int px, input int py,
                            input int view);
    reg_write(CFG_STEPS_PER_CELL, 16'(spc));
    reg_write(CFG_MAX_DISTANCE, 16'(maxd));
    reg_write(CFG_PLAYER_X, 16'(px));
    reg_write(CFG_PLAYER_Y, 16'(py));
    reg_write(CFG_VIEW_ANGLE, 16'(view));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every item went in and every result came back, then let the
  // engine finish any trailing map writes.
  task automatic drain();
    while (pend_q.size() > 0 || in_tvalid) @(posedge clk);
    while (dist_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic push_item(input logic kind, input int col, input int row,
                           input logic solid, input int angle);
    ray_req_t r;
    r.kind = kind;
    r.col = 6'(col);
    r.row = 6'(row);
    r.solid = solid;
    r.angle = 12'(angle);
    pend_q.push_back(r);
  endtask

  // One random item: mostly casts over a map of scattered walls.
  task automatic push_random(input int wall_odds);
    if ($urandom_range(0, 9) < 4)
      push_item(REQ_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 99) < wall_odds, $urandom_range(0, 4095));
    else
      push_item(REQ_CAST, $urandom_range(0, 63), $urandom_range(0, 63),
                1'($urandom_range(0, 1)), $urandom_range(0, 4095));
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_send = 1'b0;
    gap_left = 0;
    burst_left = 4;
    stall_cnt = 0;
    stall_mode = 1'b0;
    stall_pat = 16'hA5C3;
    err_cnt = 0;
    cyc = 0;
    m_spc = 50;
    m_maxd = 11;
    m_px = 0;
    m_py = 0;
    m_view = 0;
    for (int i = 0; i < 4096; i++) map_img[i] = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: defaults, axis angles, far corner, solid start cell.
    push_item(REQ_CAST, 0, 0, 0, 0);
    push_item(REQ_CAST, 63, 63, 1, 1024);
    push_item(REQ_CAST, 0, 0, 0, 2048);
    push_item(REQ_CAST, 0, 0, 0, 3072);
    push_item(REQ_CAST, 0, 0, 0, 4095);
    push_item(REQ_CAST, 0, 0, 0, 512);
    push_item(REQ_WRITE, 63, 63, 1, 4095);
    push_item(REQ_WRITE, 5, 0, 1, 0);
    push_item(REQ_CAST, 0, 0, 0, 0);
    push_item(REQ_WRITE, 0, 0, 1, 0);
    push_item(REQ_CAST, 0, 0, 0, 1024);
    push_item(REQ_WRITE, 0, 0, 0, 0);
    drain();

    // View a half turn off, player mid-map: negative correction gives zero.
    set_config(16, 20, 32 << 10, 32 << 10, 2048);
    push_item(REQ_CAST, 0, 0, 0, 0);
    push_item(REQ_CAST, 0, 0, 0, 1000);
    push_item(REQ_CAST, 0, 0, 0, 1024);
    push_item(REQ_CAST, 0, 0, 0, 3072);
    drain();

    // Zero registers: no step at all.
    set_config(0, 0, 65535, 1000, 4095);
    push_item(REQ_CAST, 0, 0, 0, 100);
    push_item(REQ_CAST, 0, 0, 0, 4095);
    drain();

    // Smallest nonzero limits.
    set_config(1, 1, 12345, 54321, 77);
    for (int i = 0; i < 8; i++) push_item(REQ_CAST, 0, 0, 0, $urandom_range(0, 4095));
    drain();

    // Largest limits, open map near the center; only a few slow casts.
    set_config(255, 63, 32 << 10, 32 << 10, 0);
    for (int i = 0; i < 3; i++) push_item(REQ_CAST, 0, 0, 0, $urandom_range(0, 4095));
    drain();

    // Random phases with scattered walls.
    for (int p = 0; p < 14; p++) begin
      set_config($urandom_range(1, 30), $urandom_range(1, 16), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 4095));
      if (p % 3 == 0) begin
        // Center the player so rays cross more of the map.
        reg_write(CFG_PLAYER_X, 16'($urandom_range(10 << 10, 54 << 10)));
        reg_write(CFG_PLAYER_Y, 16'($urandom_range(10 << 10, 54 << 10)));
        @(negedge clk);
        cfg_valid <= 1'b0;
      end
      for (int i = 0; i < 55; i++) push_random(p < 7 ? 15 : 30);
      if (p == 5) begin
        // Let part of the phase flow, then hold the sender until every
        // result is back.
        while (pend_q.size() > 25) @(posedge clk);
        hold_send = 1'b1;
        while (dist_q.size() > 0 || in_tvalid) @(posedge clk);
        hold_send = 1'b0;
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* grid_ray_march_distance.f */
+incdir+rtl
rtl/rgm_pkg.sv
rtl/rgm_front.sv
rtl/rgm_div.sv
rtl/rgm_march.sv
rtl/grid_ray_march_distance.sv
bench/tb_top.sv
